### design/mrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message rate limiter package
// Shared widths, reset values, register indexes, status codes and the
// decision record handed from the policy logic to the top level.
// ----------------------------------------------------------------------------
package mrl_pkg;

    // Default sizing of the per-ID table.
    localparam int MSG_IDS_DEF   = 1024;
    localparam int TIME_BITS_DEF = 48;

    // Fixed field widths of the ports.
    localparam int ID_W      = 10;
    localparam int NOW_W     = 48;
    localparam int ELAPSED_W = 49;
    localparam int COUNT_W   = 32;
    localparam int WINDOW_W  = 32;
    localparam int GAP_W     = 16;
    localparam int MAXC_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Wide enough to hold any ID against the largest table size.
    localparam int ID_EXT_W = 17;

    // Configuration register reset values.
    localparam logic [WINDOW_W-1:0] WINDOW_RST    = 32'd1000;
    localparam logic [GAP_W-1:0]    MIN_GAP_RST   = 16'd0;
    localparam logic [MAXC_W-1:0]   MAX_COUNT_RST = 16'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW    = 2'd0,
        REG_MIN_GAP   = 2'd1,
        REG_MAX_COUNT = 2'd2
    } cfg_reg_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ACCEPT  = 2'd0,
        ST_GAP     = 2'd1,
        ST_OVER    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // Outcome of one transaction as seen by the policy logic.
    typedef struct packed {
        logic                        wr_en;
        status_t                     status;
        logic signed [ELAPSED_W-1:0] elapsed;
        logic [COUNT_W-1:0]          window_count;
    } decision_t;

endpackage

### design/message_rate_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message rate limiter
// Fixed-window rate limiter policed per message ID. A per-ID entry of window start,
// last arrival and count is read, checked and stored unless ST_INVALID or ST_GAP.
// ----------------------------------------------------------------------------
// The input transaction is captured together with its table read; the result
// is registered in S_EXEC once the result channel is free. A new transaction
// is taken only in S_IDLE, after the read and write-back of the last one.
// Reset: synchronous, active low. The control and configuration registers
// take their reset values at once; the table is then cleared one entry a
// cycle, during which s_ready stays low. Configuration writes are taken throughout.
module message_rate_limiter #(
    parameter int MSG_IDS   = mrl_pkg::MSG_IDS_DEF,
    parameter int TIME_BITS = mrl_pkg::TIME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [mrl_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [mrl_pkg::CFG_W-1:0]         cfg_wdata,
    // Input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mrl_pkg::ID_W-1:0]          s_msg_id,
    input  logic [mrl_pkg::NOW_W-1:0]         s_now_ms,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_status,
    output logic signed [mrl_pkg::ELAPSED_W-1:0] m_elapsed_ms,
    output logic [mrl_pkg::COUNT_W-1:0]       m_window_count
);

    localparam int TW     = (TIME_BITS < mrl_pkg::NOW_W) ? TIME_BITS : mrl_pkg::NOW_W;
    localparam int IW     = (MSG_IDS > 1) ? $clog2(MSG_IDS) : 1;
    localparam int WORD_W = 2 * TW + mrl_pkg::COUNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(MSG_IDS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [IW-1:0]                  clr_idx_reg;
    logic [mrl_pkg::ID_W-1:0]       id_reg;
    logic [TW-1:0]                  now_reg;
    logic                           m_valid_reg;
    mrl_pkg::status_t               status_reg;
    logic signed [mrl_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic [mrl_pkg::COUNT_W-1:0]    count_reg;
    logic [mrl_pkg::WINDOW_W-1:0]   window_reg;
    logic [mrl_pkg::GAP_W-1:0]      min_gap_reg;
    logic [mrl_pkg::MAXC_W-1:0]     max_count_reg;

    logic                           in_fire;
    logic                           out_free;
    logic                           exec_done;
    logic [mrl_pkg::ID_EXT_W-1:0]   s_id_ext;
    logic [mrl_pkg::ID_EXT_W-1:0]   id_reg_ext;
    logic [IW-1:0]                  rd_addr;
    logic [WORD_W-1:0]              rd_data;
    logic                           wr_en;
    logic [IW-1:0]                  wr_addr;
    logic [WORD_W-1:0]              wr_data;
    logic [WORD_W-1:0]              entry_new;
    mrl_pkg::decision_t             decision;

    // Handshake qualifiers.
    assign s_ready   = (state_reg == S_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_done = (state_reg == S_EXEC) && out_free;

    // Table addressing: out-of-range IDs alias harmlessly, they are never written.
    assign s_id_ext   = mrl_pkg::ID_EXT_W'(s_msg_id);
    assign id_reg_ext = mrl_pkg::ID_EXT_W'(id_reg);
    assign rd_addr    = s_id_ext[IW-1:0];

    // Write port is shared between the clearing pass and the write-back.
    always_comb begin
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end else begin
            wr_en   = exec_done && decision.wr_en;
            wr_addr = id_reg_ext[IW-1:0];
            wr_data = entry_new;
        end
    end

    mrl_table #(
        .DEPTH  (MSG_IDS),
        .ADDR_W (IW),
        .DATA_W (WORD_W)
    ) u_table (
        .aclk    (aclk),
        .rd_en   (in_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mrl_policy #(
        .MSG_IDS (MSG_IDS),
        .TW      (TW)
    ) u_policy (
        .msg_id     (id_reg),
        .now        (now_reg),
        .entry_in   (rd_data),
        .window_ms  (window_reg),
        .min_gap_ms (min_gap_reg),
        .max_count  (max_count_reg),
        .entry_out  (entry_new),
        .decision   (decision)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // State, clearing index and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (exec_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Captured transaction and result payload.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            id_reg  <= s_msg_id;
            now_reg <= s_now_ms[TW-1:0];
        end
        if (exec_done) begin
            status_reg  <= decision.status;
            elapsed_reg <= decision.elapsed;
            count_reg   <= decision.window_count;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= mrl_pkg::WINDOW_RST;
            min_gap_reg   <= mrl_pkg::MIN_GAP_RST;
            max_count_reg <= mrl_pkg::MAX_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                mrl_pkg::REG_WINDOW:    window_reg    <= cfg_wdata[mrl_pkg::WINDOW_W-1:0];
                mrl_pkg::REG_MIN_GAP:   min_gap_reg   <= cfg_wdata[mrl_pkg::GAP_W-1:0];
                mrl_pkg::REG_MAX_COUNT: max_count_reg <= cfg_wdata[mrl_pkg::MAXC_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_elapsed_ms   = elapsed_reg;
    assign m_window_count = count_reg;

endmodule

### design/mrl_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message rate limiter state table
// Single-port-read, single-port-write synchronous memory holding one packed
// entry per message ID. Read data is registered.
// ----------------------------------------------------------------------------
module mrl_table #(
    parameter int DEPTH  = mrl_pkg::MSG_IDS_DEF,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 128
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/mrl_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message rate limiter policy
// Applies the fixed-window rules to one table entry and one arrival, giving
// the updated entry and the result of the transaction.
// ----------------------------------------------------------------------------
module mrl_policy #(
    parameter int MSG_IDS = mrl_pkg::MSG_IDS_DEF,
    parameter int TW      = mrl_pkg::TIME_BITS_DEF
) (
    input  logic [mrl_pkg::ID_W-1:0]     msg_id,
    input  logic [TW-1:0]                now,
    input  logic [2*TW+mrl_pkg::COUNT_W-1:0] entry_in,
    input  logic [mrl_pkg::WINDOW_W-1:0] window_ms,
    input  logic [mrl_pkg::GAP_W-1:0]    min_gap_ms,
    input  logic [mrl_pkg::MAXC_W-1:0]   max_count,
    output logic [2*TW+mrl_pkg::COUNT_W-1:0] entry_out,
    output mrl_pkg::decision_t           decision
);

    localparam int CW = (TW + 1 > mrl_pkg::WINDOW_W + 1) ? TW + 1 : mrl_pkg::WINDOW_W + 1;
    localparam logic [mrl_pkg::ID_EXT_W-1:0] ID_LIMIT = mrl_pkg::ID_EXT_W'(MSG_IDS);
    localparam logic [mrl_pkg::COUNT_W-1:0]  COUNT_MAX = '1;

    logic [TW-1:0]                  win_start;
    logic [TW-1:0]                  last_arr;
    logic [mrl_pkg::COUNT_W-1:0]    count;
    logic [mrl_pkg::ID_EXT_W-1:0]   id_ext;
    logic                           id_ok;
    logic                           unseen;
    logic signed [TW:0]             gap;
    logic signed [TW:0]             win_diff;
    logic signed [CW-1:0]           gap_w;
    logic signed [CW-1:0]           min_gap_w;
    logic signed [CW-1:0]           win_diff_w;
    logic signed [CW-1:0]           window_w;
    logic                           gap_short;
    logic                           restart;
    logic [mrl_pkg::COUNT_W-1:0]    count_inc;
    logic [mrl_pkg::COUNT_W-1:0]    count_new;
    logic [mrl_pkg::COUNT_W-1:0]    max_count_w;
    logic                           over_restart;
    logic                           over_inc;
    logic                           over;
    logic [TW-1:0]                  win_start_new;

    assign {win_start, last_arr, count} = entry_in;

    // ID range check.
    assign id_ext = mrl_pkg::ID_EXT_W'(msg_id);
    assign id_ok  = (msg_id != '0) && (id_ext < ID_LIMIT);
    assign unseen = (win_start == '0);

    // Signed time differences, one bit wider than the timestamps.
    assign gap      = $signed({1'b0, now}) - $signed({1'b0, last_arr});
    assign win_diff = $signed({1'b0, now}) - $signed({1'b0, win_start});

    // Compare in a common width wide enough for both operands.
    assign gap_w      = CW'(gap);
    assign win_diff_w = CW'(win_diff);
    assign min_gap_w  = $signed(CW'(min_gap_ms));
    assign window_w   = $signed(CW'(window_ms));
    assign gap_short  = gap_w < min_gap_w;
    assign restart    = win_diff_w > window_w;

    // Count update: both outcomes are worked out side by side, then selected.
    assign max_count_w  = mrl_pkg::COUNT_W'(max_count);
    assign count_inc    = (count == COUNT_MAX) ? count : count + 1'b1;
    assign count_new    = restart ? mrl_pkg::COUNT_W'(1) : count_inc;
    assign over_restart = (max_count == '0);
    assign over_inc     = count_inc > max_count_w;
    assign over         = restart ? over_restart : over_inc;
    assign win_start_new = restart ? now : win_start;

    // Rule selection, in order of precedence.
    always_comb begin
        decision              = '0;
        decision.status       = mrl_pkg::ST_ACCEPT;
        entry_out             = {win_start_new, now, count_new};
        if (!id_ok) begin
            decision.status = mrl_pkg::ST_INVALID;
        end else if (unseen) begin
            decision.wr_en = 1'b1;
            entry_out      = {now, now, mrl_pkg::COUNT_W'(1)};
        end else if (gap_short) begin
            decision.status  = mrl_pkg::ST_GAP;
            decision.elapsed = mrl_pkg::ELAPSED_W'(gap);
        end else begin
            decision.wr_en = 1'b1;
            if (over) begin
                decision.status       = mrl_pkg::ST_OVER;
                decision.elapsed      = restart ? '0 : mrl_pkg::ELAPSED_W'(win_diff);
                decision.window_count = count_new;
            end
        end
    end

endmodule
